### design/mthq_pkg.sv
// Shared types and constants for the min-heap timer queue.
// Used by mthq_cmp, mthq_core and min_heap_timer_queue_top; depends on nothing.
package mthq_pkg;

    localparam int ID_W   = 8;
    localparam int EXP_W  = 40;
    localparam int TMO_W  = 31;
    localparam int NEXT_W = 31;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADJUST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIRE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Completion status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DISP,
        ST_DN_RD1,
        ST_DN_RD2,
        ST_DN_SEL,
        ST_DN_CMP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_PLACE,
        ST_RM_RD,
        ST_RM_LOAD,
        ST_X_RD,
        ST_X_CHK,
        ST_EMIT_FIRE,
        ST_EMIT_DONE
    } state_t;

    typedef struct packed {
        logic              event_kind;
        logic [ID_W-1:0]   fired_id;
        logic [STAT_W-1:0] status;
        logic [NEXT_W-1:0] next_ms;
        logic              queue_empty;
        logic              last;
    } res_t;

    typedef struct packed {
        logic             lt;
        logic             eq;
        logic [EXP_W-1:0] diff;
    } cmp_res_t;

endpackage

### design/mthq_cmp.sv
// Shared expiry compare and subtract unit: a < b, a == b, a - b.
// Depends on mthq_pkg.
module mthq_cmp (
    input  logic [mthq_pkg::EXP_W-1:0] a,
    input  logic [mthq_pkg::EXP_W-1:0] b,
    output mthq_pkg::cmp_res_t         res
);
    import mthq_pkg::*;

    logic [EXP_W:0] sub;

    // Borrow of a - b gives a < b
    assign sub      = {1'b0, a} - {1'b0, b};
    assign res.lt   = sub[EXP_W];
    assign res.eq   = (a == b);
    assign res.diff = sub[EXP_W-1:0];

endmodule

### design/mthq_core.sv
// Heap sequencer: slot and id tables in memories, sift walks through the shared compare unit.
// Depends on mthq_pkg and mthq_cmp.
module mthq_core #(
    parameter int CAPACITY = 32,
    parameter int ID_SPACE = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [mthq_pkg::MODE_W-1:0] req_mode,
    input  logic [mthq_pkg::ID_W-1:0]   req_id,
    input  logic [mthq_pkg::TMO_W-1:0]  req_timeout,
    input  logic [mthq_pkg::EXP_W-1:0]  req_now,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mthq_pkg::res_t              res
);
    import mthq_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(ID_SPACE);
    localparam int CH_W   = SLOT_W + 2;

    // Heap slot storage and id-to-slot table
    logic [EXP_W-1:0]  exp_mem [CAPACITY];
    logic [ID_W-1:0]   own_mem [CAPACITY];
    logic [SLOT_W-1:0] slot_mem [ID_SPACE];

    logic [EXP_W-1:0]  rd_exp_q;
    logic [ID_W-1:0]   rd_own_q;
    logic [SLOT_W-1:0] slot_q;

    logic              hw_en;
    logic [SLOT_W-1:0] hw_addr;
    logic [EXP_W-1:0]  hw_exp;
    logic [ID_W-1:0]   hw_own;
    logic [SLOT_W-1:0] hr_addr;
    logic              iw_en;
    logic [IDX_W-1:0]  iw_addr;
    logic [SLOT_W-1:0] iw_data;

    // Control and working registers
    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [EXP_W-1:0]  now_reg, now_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_SPACE-1:0] present_reg, present_next;
    logic [EXP_W-1:0]  cur_exp_reg, cur_exp_next;
    logic [ID_W-1:0]   cur_own_reg, cur_own_next;
    logic [SLOT_W-1:0] i_reg, i_next;
    logic [SLOT_W-1:0] start_reg, start_next;
    logic              up_after_reg, up_after_next;
    logic [EXP_W-1:0]  ch_exp_reg, ch_exp_next;
    logic [ID_W-1:0]   ch_own_reg, ch_own_next;
    logic [SLOT_W-1:0] ch_idx_reg, ch_idx_next;
    logic [ID_W-1:0]   fire_id_reg, fire_id_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [NEXT_W-1:0] next_ms_reg, next_ms_next;

    // Shared compare unit
    logic [EXP_W-1:0]  cmp_a;
    logic [EXP_W-1:0]  cmp_b;
    cmp_res_t          cmp_r;

    mthq_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_r)
    );

    // Derived indexes
    logic [CH_W-1:0]   c1;
    logic [CH_W-1:0]   c2;
    logic [CH_W-1:0]   n_ext;
    logic [SLOT_W-1:0] parent;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  idx;
    logic              id_ok;
    logic              known;
    logic [EXP_W:0]    sum;

    assign c1     = CH_W'({i_reg, 1'b1});
    assign c2     = c1 + CH_W'(1);
    assign n_ext  = CH_W'(count_reg);
    assign parent = (i_reg - SLOT_W'(1)) >> 1;
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign idx    = IDX_W'(id_reg);
    assign id_ok  = int'(id_reg) < ID_SPACE;
    assign known  = id_ok && present_reg[idx];
    assign sum    = {1'b0, req_now} + (EXP_W + 1)'(req_timeout);

    // Slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            exp_mem[hw_addr] <= hw_exp;
            own_mem[hw_addr] <= hw_own;
        end
        rd_exp_q <= exp_mem[hr_addr];
        rd_own_q <= own_mem[hr_addr];
    end

    // Id table memory
    always_ff @(posedge clk)
    begin
        if (iw_en)
        begin
            slot_mem[iw_addr] <= iw_data;
        end
        slot_q <= slot_mem[idx];
    end

    // Next state and working registers
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        now_next      = now_reg;
        exp_next      = exp_reg;
        count_next    = count_reg;
        present_next  = present_reg;
        cur_exp_next  = cur_exp_reg;
        cur_own_next  = cur_own_reg;
        i_next        = i_reg;
        start_next    = start_reg;
        up_after_next = up_after_reg;
        ch_exp_next   = ch_exp_reg;
        ch_own_next   = ch_own_reg;
        ch_idx_next   = ch_idx_reg;
        fire_id_next  = fire_id_reg;
        status_next   = status_reg;
        next_ms_next  = next_ms_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req_mode;
                    id_next    = req_id;
                    now_next   = req_now;
                    exp_next   = sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_DISP;
            end
            ST_DISP:
            begin
                status_next  = STAT_OK;
                next_ms_next = '0;
                cur_exp_next = exp_reg;
                cur_own_next = id_reg;
                state_next   = ST_EMIT_DONE;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        if (known)
                        begin
                            i_next        = slot_q;
                            start_next    = slot_q;
                            up_after_next = 1'b1;
                            state_next    = ST_DN_RD1;
                        end
                        else if (!id_ok)
                        begin
                            status_next = STAT_ABSENT;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            present_next[idx] = 1'b1;
                            i_next            = count_reg[SLOT_W-1:0];
                            count_next        = count_reg + CNT_W'(1);
                            state_next        = ST_UP_RD;
                        end
                    end
                    MODE_ADJUST:
                    begin
                        if (known)
                        begin
                            i_next        = slot_q;
                            start_next    = slot_q;
                            up_after_next = 1'b0;
                            state_next    = ST_DN_RD1;
                        end
                        else
                        begin
                            status_next = STAT_ABSENT;
                        end
                    end
                    MODE_FIRE:
                    begin
                        if (known)
                        begin
                            present_next[idx] = 1'b0;
                            fire_id_next      = id_reg;
                            i_next            = slot_q;
                            state_next        = ST_RM_RD;
                        end
                        else
                        begin
                            status_next = STAT_ABSENT;
                        end
                    end
                    MODE_EXPIRE:
                    begin
                        state_next = ST_X_RD;
                    end
                    MODE_CLEAR:
                    begin
                        count_next   = '0;
                        present_next = '0;
                    end
                    default:
                    begin
                        state_next = ST_EMIT_DONE;
                    end
                endcase
            end
            ST_DN_RD1:
            begin
                if (c1 < n_ext)
                begin
                    state_next = ST_DN_RD2;
                end
                else if (i_reg == start_reg && up_after_reg)
                begin
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_DN_RD2:
            begin
                ch_exp_next = rd_exp_q;
                ch_own_next = rd_own_q;
                ch_idx_next = c1[SLOT_W-1:0];
                state_next  = (c2 < n_ext) ? ST_DN_SEL : ST_DN_CMP;
            end
            ST_DN_SEL:
            begin
                // take the right child when strictly smaller
                if (cmp_r.lt)
                begin
                    ch_exp_next = rd_exp_q;
                    ch_own_next = rd_own_q;
                    ch_idx_next = c2[SLOT_W-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (cmp_r.lt)
                begin
                    i_next     = ch_idx_reg;
                    state_next = ST_DN_RD1;
                end
                else if (i_reg == start_reg && up_after_reg)
                begin
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_UP_RD:
            begin
                state_next = (i_reg == '0) ? ST_PLACE : ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                if (cmp_r.lt)
                begin
                    i_next     = parent;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = (mode_reg == MODE_FIRE || mode_reg == MODE_EXPIRE) ?
                             ST_EMIT_FIRE : ST_EMIT_DONE;
            end
            ST_RM_RD:
            begin
                count_next = cnt_m1;
                state_next = (CNT_W'(i_reg) < cnt_m1) ? ST_RM_LOAD : ST_EMIT_FIRE;
            end
            ST_RM_LOAD:
            begin
                cur_exp_next  = rd_exp_q;
                cur_own_next  = rd_own_q;
                start_next    = i_reg;
                up_after_next = 1'b1;
                state_next    = ST_DN_RD1;
            end
            ST_X_RD:
            begin
                if (count_reg == '0)
                begin
                    next_ms_next = '0;
                    state_next   = ST_EMIT_DONE;
                end
                else
                begin
                    state_next = ST_X_CHK;
                end
            end
            ST_X_CHK:
            begin
                if (cmp_r.lt || cmp_r.eq)
                begin
                    present_next[IDX_W'(rd_own_q)] = 1'b0;
                    fire_id_next = rd_own_q;
                    i_next       = '0;
                    state_next   = ST_RM_RD;
                end
                else
                begin
                    next_ms_next = (cmp_r.diff[EXP_W-1:NEXT_W] != '0) ?
                                   {NEXT_W{1'b1}} : cmp_r.diff[NEXT_W-1:0];
                    state_next   = ST_EMIT_DONE;
                end
            end
            ST_EMIT_FIRE:
            begin
                if (res_ready)
                begin
                    state_next = (mode_reg == MODE_FIRE) ? ST_EMIT_DONE : ST_X_RD;
                end
            end
            ST_EMIT_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory ports, compare operands and result
    always_comb
    begin
        hw_en     = 1'b0;
        hw_addr   = i_reg;
        hw_exp    = cur_exp_reg;
        hw_own    = cur_own_reg;
        hr_addr   = c1[SLOT_W-1:0];
        iw_en     = 1'b0;
        iw_addr   = IDX_W'(cur_own_reg);
        iw_data   = i_reg;
        cmp_a     = ch_exp_reg;
        cmp_b     = cur_exp_reg;
        res_valid = 1'b0;
        res       = '0;
        req_stall = (state_reg != ST_IDLE);
        res.queue_empty = (count_reg == '0);
        case (state_reg)
            ST_DN_RD1:
            begin
                hr_addr = c1[SLOT_W-1:0];
            end
            ST_DN_RD2:
            begin
                hr_addr = c2[SLOT_W-1:0];
            end
            ST_DN_SEL:
            begin
                cmp_a = rd_exp_q;
                cmp_b = ch_exp_reg;
            end
            ST_DN_CMP:
            begin
                // move the smaller child up into the hole
                cmp_a   = ch_exp_reg;
                cmp_b   = cur_exp_reg;
                hw_en   = cmp_r.lt;
                hw_exp  = ch_exp_reg;
                hw_own  = ch_own_reg;
                iw_en   = cmp_r.lt;
                iw_addr = IDX_W'(ch_own_reg);
            end
            ST_UP_RD:
            begin
                hr_addr = parent;
            end
            ST_UP_CMP:
            begin
                // move the parent down into the hole
                cmp_a   = cur_exp_reg;
                cmp_b   = rd_exp_q;
                hw_en   = cmp_r.lt;
                hw_exp  = rd_exp_q;
                hw_own  = rd_own_q;
                iw_en   = cmp_r.lt;
                iw_addr = IDX_W'(rd_own_q);
            end
            ST_PLACE:
            begin
                hw_en = 1'b1;
                iw_en = 1'b1;
            end
            ST_RM_RD:
            begin
                hr_addr = cnt_m1[SLOT_W-1:0];
            end
            ST_X_RD:
            begin
                hr_addr = '0;
            end
            ST_X_CHK:
            begin
                cmp_a = rd_exp_q;
                cmp_b = now_reg;
            end
            ST_EMIT_FIRE:
            begin
                res_valid      = 1'b1;
                res.event_kind = 1'b1;
                res.fired_id   = fire_id_reg;
            end
            ST_EMIT_DONE:
            begin
                res_valid    = 1'b1;
                res.status   = status_reg;
                res.next_ms  = next_ms_reg;
                res.last     = 1'b1;
                res.fired_id = (mode_reg == MODE_ADD || mode_reg == MODE_ADJUST ||
                                mode_reg == MODE_FIRE) ? id_reg : '0;
            end
            default:
            begin
                hw_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            present_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            present_reg <= present_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        now_reg      <= now_next;
        exp_reg      <= exp_next;
        cur_exp_reg  <= cur_exp_next;
        cur_own_reg  <= cur_own_next;
        i_reg        <= i_next;
        start_reg    <= start_next;
        up_after_reg <= up_after_next;
        ch_exp_reg   <= ch_exp_next;
        ch_own_reg   <= ch_own_next;
        ch_idx_reg   <= ch_idx_next;
        fire_id_reg  <= fire_id_next;
        status_reg   <= status_next;
        next_ms_reg  <= next_ms_next;
    end

endmodule

### design/min_heap_timer_queue_top.sv
// A request passes the lookup and dispatch states before its completion. A sift walks the heap
// level by level, up or down, and ends with a final write; a removal first reads the last entry
// into the hole. Expire requests check the head and repeat a removal per fired timer.
// Throughput: one request at a time; the next is taken in the cycle after the completion
// leaves the core, and an output stall holds the core.
// Reset (rst_n, async low): queue empty, all ids absent; slot memories are not cleared.
module min_heap_timer_queue_top #(
    parameter int CAPACITY = 32,
    parameter int ID_SPACE = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mthq_pkg::MODE_W-1:0] mode,
    input  logic [mthq_pkg::ID_W-1:0]   timer_id,
    input  logic [mthq_pkg::TMO_W-1:0]  timeout_ms,
    input  logic [mthq_pkg::EXP_W-1:0]  now_ms,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        event_kind,
    output logic [mthq_pkg::ID_W-1:0]   fired_id,
    output logic [mthq_pkg::STAT_W-1:0] status,
    output logic [mthq_pkg::NEXT_W-1:0] next_ms,
    output logic                        queue_empty,
    output logic                        last
);
    import mthq_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    mthq_core #(
        .CAPACITY (CAPACITY),
        .ID_SPACE (ID_SPACE)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (in_valid),
        .req_stall   (in_stall),
        .req_mode    (mode),
        .req_id      (timer_id),
        .req_timeout (timeout_ms),
        .req_now     (now_ms),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Load the output register when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = out_reg.event_kind;
    assign fired_id    = out_reg.fired_id;
    assign status      = out_reg.status;
    assign next_ms     = out_reg.next_ms;
    assign queue_empty = out_reg.queue_empty;
    assign last        = out_reg.last;

`ifndef SYNTHESIS
    // Block goes busy right after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while block stays ready");

    // Fired events are never final, completions always are
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind != last))
        else $error("event kind and last flag disagree");

    // Fired events carry no status and no remaining time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind |-> (status == STAT_OK) && (next_ms == '0))
        else $error("fired event with status or next time");
`endif

endmodule
